// ----- src/tsni_pkg.sv -----
// Package for the TLS server name locator: parse phase type, header
// constants and the result word shared by the parser and the output stage.
// No dependencies.
`default_nettype none

package tsni_pkg;

    // Parse phases of the ClientHello walk
    typedef enum logic [3:0] {
        PH_REC_TYPE   = 4'd0,
        PH_HELLO_TYPE = 4'd1,
        PH_SID_LEN    = 4'd2,
        PH_CS_HI      = 4'd3,
        PH_CS_LO      = 4'd4,
        PH_CM_LEN     = 4'd5,
        PH_EXTS_LEN   = 4'd6,
        PH_EXT_T0     = 4'd7,
        PH_EXT_T1     = 4'd8,
        PH_EXT_L0     = 4'd9,
        PH_EXT_L1     = 4'd10,
        PH_NAME_LEN   = 4'd11,
        PH_NAME_FIRST = 4'd12,
        PH_DONE       = 4'd13
    } t_phase;

    // Type bytes that must be present
    localparam logic [7:0] REC_TYPE_HANDSHAKE = 8'h16;
    localparam logic [7:0] HS_TYPE_CLIENT_HELLO = 8'h01;
    localparam logic [7:0] EXT_TYPE_BYTE_SNI = 8'h00;

    // Fixed skip counts loaded by the parse phases
    localparam logic [15:0] REC_HDR_SKIP = 16'd4;
    localparam logic [15:0] HELLO_FIXED_SKIP = 16'd37;
    localparam logic [15:0] EXTS_LEN_SKIP = 16'd1;
    localparam logic [15:0] SNI_HDR_SKIP = 16'd4;

    // One result word
    typedef struct packed {
        logic        found;
        logic [15:0] name_start;
        logic [15:0] name_end;
    } t_result;

endpackage

`default_nettype wire

// ----- src/tsni_in_stage.sv -----
// Input register of the TLS server name locator: holds one payload byte and
// its last flag until the parser takes it. Depends on nothing.
`default_nettype none

module tsni_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_payload_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_take,
    output logic            o_held_valid,
    output logic [7:0]      o_held_byte,
    output logic            o_held_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       s_accept;

    // Room when empty or when the held word leaves this cycle
    assign o_in_ready = !r_valid || i_take;
    assign s_accept   = i_in_valid && o_in_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the payload word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_byte <= i_payload_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_byte  = r_byte;
    assign o_held_last  = r_last;

endmodule

`default_nettype wire

// ----- src/tsni_parser.sv -----
// ClientHello parser: phase machine, skip counter and byte offset, and the
// result word formed at the last byte. Depends on tsni_pkg.
`default_nettype none

module tsni_parser #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output tsni_pkg::t_result o_result
);

    localparam logic [OFFSET_BITS-1:0] OffsetMax = '1;
    localparam logic [OFFSET_BITS-1:0] OffsetOne = OFFSET_BITS'(1);
    localparam int WideBits = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    tsni_pkg::t_phase r_phase, n_phase, s_phase;
    logic [OFFSET_BITS-1:0] r_offset, n_offset, s_offset;
    logic [15:0]            r_count, n_count, s_count;
    logic [7:0]             r_len_hi, n_len_hi, s_len_hi;
    logic                   r_type_zero, n_type_zero, s_type_zero;
    logic                   r_failed, n_failed, s_failed;
    logic                   r_found, n_found, s_found;
    logic [OFFSET_BITS-1:0] r_name_off, n_name_off, s_name_off;
    logic [OFFSET_BITS:0]   r_end_full, n_end_full, s_end_full;

    logic [OFFSET_BITS:0]   s_len_full;
    logic [OFFSET_BITS-1:0] s_end_sel;
    logic [WideBits-1:0]    s_start_wide;
    logic [WideBits-1:0]    s_end_wide;

    // Parse one byte: next phase, counters and name fields
    always_comb begin
        s_phase     = r_phase;
        s_offset    = r_offset;
        s_count     = r_count;
        s_len_hi    = r_len_hi;
        s_type_zero = r_type_zero;
        s_failed    = r_failed;
        s_found     = r_found;
        s_name_off  = r_name_off;
        s_end_full  = r_end_full;
        if (i_step) begin
            if (r_offset == OffsetMax) begin
                s_failed = 1'b1;
            end
            if (!s_failed && r_phase != tsni_pkg::PH_DONE) begin
                if (r_count != 16'd0) begin
                    s_count = r_count - 16'd1;
                end else begin
                    unique case (r_phase)
                        tsni_pkg::PH_REC_TYPE: begin
                            if (i_byte != tsni_pkg::REC_TYPE_HANDSHAKE) begin
                                s_failed = 1'b1;
                            end else begin
                                s_count = tsni_pkg::REC_HDR_SKIP;
                                s_phase = tsni_pkg::PH_HELLO_TYPE;
                            end
                        end
                        tsni_pkg::PH_HELLO_TYPE: begin
                            if (i_byte != tsni_pkg::HS_TYPE_CLIENT_HELLO) begin
                                s_failed = 1'b1;
                            end else begin
                                s_count = tsni_pkg::HELLO_FIXED_SKIP;
                                s_phase = tsni_pkg::PH_SID_LEN;
                            end
                        end
                        tsni_pkg::PH_SID_LEN: begin
                            s_count = {8'd0, i_byte};
                            s_phase = tsni_pkg::PH_CS_HI;
                        end
                        tsni_pkg::PH_CS_HI: begin
                            s_len_hi = i_byte;
                            s_phase  = tsni_pkg::PH_CS_LO;
                        end
                        tsni_pkg::PH_CS_LO: begin
                            s_count = {r_len_hi, i_byte};
                            s_phase = tsni_pkg::PH_CM_LEN;
                        end
                        tsni_pkg::PH_CM_LEN: begin
                            s_count = {8'd0, i_byte};
                            s_phase = tsni_pkg::PH_EXTS_LEN;
                        end
                        tsni_pkg::PH_EXTS_LEN: begin
                            s_count = tsni_pkg::EXTS_LEN_SKIP;
                            s_phase = tsni_pkg::PH_EXT_T0;
                        end
                        tsni_pkg::PH_EXT_T0: begin
                            s_type_zero = (i_byte == tsni_pkg::EXT_TYPE_BYTE_SNI);
                            s_phase     = tsni_pkg::PH_EXT_T1;
                        end
                        tsni_pkg::PH_EXT_T1: begin
                            s_type_zero = r_type_zero &&
                                          (i_byte == tsni_pkg::EXT_TYPE_BYTE_SNI);
                            s_phase     = tsni_pkg::PH_EXT_L0;
                        end
                        tsni_pkg::PH_EXT_L0: begin
                            s_len_hi = i_byte;
                            s_phase  = tsni_pkg::PH_EXT_L1;
                        end
                        tsni_pkg::PH_EXT_L1: begin
                            if (r_type_zero) begin
                                s_count = tsni_pkg::SNI_HDR_SKIP;
                                s_phase = tsni_pkg::PH_NAME_LEN;
                            end else begin
                                s_count = {r_len_hi, i_byte};
                                s_phase = tsni_pkg::PH_EXT_T0;
                            end
                        end
                        tsni_pkg::PH_NAME_LEN: begin
                            if (i_byte == 8'd0) begin
                                s_failed = 1'b1;
                            end else begin
                                // Name starts after this byte; keep its
                                // unclamped last offset for the end clamp
                                s_name_off = r_offset + OffsetOne;
                                s_end_full = {1'b0, r_offset} +
                                             {{(OFFSET_BITS - 7){1'b0}}, i_byte};
                                s_phase    = tsni_pkg::PH_NAME_FIRST;
                            end
                        end
                        tsni_pkg::PH_NAME_FIRST: begin
                            s_found = 1'b1;
                            s_phase = tsni_pkg::PH_DONE;
                        end
                        default: begin
                            s_phase = tsni_pkg::PH_DONE;
                        end
                    endcase
                end
            end
            // Advance the offset, saturating at the top
            if (r_offset != OffsetMax) begin
                s_offset = r_offset + OffsetOne;
            end
        end
    end

    // Start over after the last byte of a payload
    always_comb begin
        n_phase     = s_phase;
        n_offset    = s_offset;
        n_count     = s_count;
        n_len_hi    = s_len_hi;
        n_type_zero = s_type_zero;
        n_failed    = s_failed;
        n_found     = s_found;
        n_name_off  = s_name_off;
        n_end_full  = s_end_full;
        if (i_step && i_last) begin
            n_phase     = tsni_pkg::PH_REC_TYPE;
            n_offset    = '0;
            n_count     = 16'd0;
            n_len_hi    = 8'd0;
            n_type_zero = 1'b0;
            n_failed    = 1'b0;
            n_found     = 1'b0;
            n_name_off  = '0;
            n_end_full  = '0;
        end
    end

    // Form the result: clamp the name end to the payload length
    always_comb begin
        s_len_full = {1'b0, r_offset} + {{OFFSET_BITS{1'b0}}, 1'b1};
        s_end_sel  = (r_end_full > s_len_full) ? s_len_full[OFFSET_BITS-1:0]
                                               : r_end_full[OFFSET_BITS-1:0];
        s_start_wide = WideBits'(r_name_off);
        s_end_wide   = WideBits'(s_end_sel);
        o_result.found      = s_found && !s_failed;
        o_result.name_start = o_result.found ? s_start_wide[15:0] : 16'd0;
        o_result.name_end   = o_result.found ? s_end_wide[15:0] : 16'd0;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tsni_pkg::PH_REC_TYPE;
            r_offset    <= '0;
            r_count     <= 16'd0;
            r_len_hi    <= 8'd0;
            r_type_zero <= 1'b0;
            r_failed    <= 1'b0;
            r_found     <= 1'b0;
            r_name_off  <= '0;
            r_end_full  <= '0;
        end else begin
            r_phase     <= n_phase;
            r_offset    <= n_offset;
            r_count     <= n_count;
            r_len_hi    <= n_len_hi;
            r_type_zero <= n_type_zero;
            r_failed    <= n_failed;
            r_found     <= n_found;
            r_name_off  <= n_name_off;
            r_end_full  <= n_end_full;
        end
    end

endmodule

`default_nettype wire

// ----- src/tsni_out_reg.sv -----
// Result register of the TLS server name locator: holds one result word
// until the consumer takes it. Depends on tsni_pkg.
`default_nettype none

module tsni_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire tsni_pkg::t_result i_result,
    output logic                   o_free,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output tsni_pkg::t_result      o_result
);

    logic              r_valid;
    tsni_pkg::t_result r_result;

    // Free when empty or being drained this cycle
    assign o_free = !r_valid || i_out_ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ----- src/tls_sni_locator_core.sv -----
// TLS server name locator, top level: input register, parser, result
// register. Depends on tsni_pkg, tsni_in_stage, tsni_parser, tsni_out_reg.
//
// Feed the transport payload one byte per word with i_last_byte on the final
// byte; one result word (found, name start offset, clamped name end offset)
// comes out per payload. The block takes one byte every cycle unless a last
// byte waits: each byte passes the input register, and the parser updates its
// phase and counters as the byte leaves it, loading the result word into the
// result register at that same edge. Only a last byte waits, held in the input
// register, while the result register is still full; other bytes keep flowing.
// Offsets count from zero at the first payload byte; payloads of 2^OFFSET_BITS
// bytes or more report not found.
`default_nettype none

module tls_sni_locator_core #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_payload_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [15:0]      o_name_start,
    output logic [15:0]      o_name_end
);

    logic              s_held_valid;
    logic [7:0]        s_held_byte;
    logic              s_held_last;
    logic              s_step;
    logic              s_out_free;
    tsni_pkg::t_result s_result;
    tsni_pkg::t_result s_out_result;

    // Step a held byte unless it is a last byte facing a full result register
    assign s_step = s_held_valid && (!s_held_last || s_out_free);

    tsni_in_stage u_in_stage (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .i_take         (s_step),
        .o_held_valid   (s_held_valid),
        .o_held_byte    (s_held_byte),
        .o_held_last    (s_held_last)
    );

    tsni_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s_step),
        .i_byte   (s_held_byte),
        .i_last   (s_held_last),
        .o_result (s_result)
    );

    tsni_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s_step && s_held_last),
        .i_result    (s_result),
        .o_free      (s_out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (s_out_result)
    );

    assign o_found      = s_out_result.found;
    assign o_name_start = s_out_result.name_start;
    assign o_name_end   = s_out_result.name_end;

endmodule

`default_nettype wire

// ----- src/tsni_checker.sv -----
// Port-level checks for the TLS server name locator, bound to the top level.
// Depends on tls_sni_locator_core.
`default_nettype none

module tsni_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_found,
    input wire logic [15:0] o_name_start,
    input wire logic [15:0] o_name_end
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_name_start) &&
            $stable(o_name_end))
        else $error("result word changed while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // Not found reports zero offsets
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_name_start == 16'd0 && o_name_end == 16'd0)
        else $error("nonzero offsets on a miss");

    // Name span never exceeds the low length byte
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> 16'(o_name_end - o_name_start) <= 16'd254)
        else $error("name span too long");

endmodule

bind tls_sni_locator_core tsni_checker u_tsni_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_found      (o_found),
    .o_name_start (o_name_start),
    .o_name_end   (o_name_end)
);

`default_nettype wire
